FILE: hw/rtl/obn_pkg.sv
package obn_pkg;

  localparam int FracBits  = 30;
  localparam int GuardBits = 28;
  localparam int InWidth   = 32;

  // restoring square root: one result bit per step
  localparam int SqrtSteps = 30 + GuardBits + 1;
  // fractional division: one quotient bit per step
  localparam int DivSteps  = FracBits + GuardBits;

  localparam logic [30:0] UnitCap = 31'(1) << FracBits;

  // configuration register indexes (byte address bit 2)
  localparam logic RegZeroThr = 1'b0;

  typedef logic signed [62:0] wide_t;
  typedef logic signed [30:0] nint_t;
  typedef logic signed [31:0] unit_t;
  typedef logic [2:0][61:0]   mag3_t;

  typedef struct packed {
    logic signed [InWidth-1:0] normal_x;
    logic signed [InWidth-1:0] normal_y;
    logic signed [InWidth-1:0] normal_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic               degenerate;
  } out_t;

  // data riding along a normalizer
  typedef struct packed {
    nint_t [2:0] nn;
    unit_t [2:0] ua;
    logic        deg;
  } side_t;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][29:0] mag;
    side_t            side;
  } ctx_t;

  typedef struct packed {
    logic [61:0] s;
    logic [60:0] rem;
    logic [58:0] root;
  } sq_t;

  typedef struct packed {
    logic [58:0]      den;
    logic [2:0][58:0] r;
    logic [2:0][30:0] q;
  } dv_t;

  // one step of leading-zero normalization, shift by k when the top k bits are clear
  function automatic mag3_t norm_step(input mag3_t m, input int unsigned k);
    logic [61:0] orv;
    mag3_t       r;
    int          i;
    orv = m[0] | m[1] | m[2];
    r   = m;
    if ((orv >> (62 - k)) == '0) begin
      for (i = 0; i < 3; i++) r[i] = m[i] << k;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/obn_sqrt_cell.sv
module obn_sqrt_cell import obn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  sq_t  sq_i,
  input  ctx_t ctx_i,
  output logic vld_o,
  output sq_t  sq_o,
  output ctx_t ctx_o
);

  logic [62:0] rem4, trial;
  logic        ge;
  sq_t         sq_d, sq_q;
  ctx_t        ctx_q;
  logic        vld_q;

  // bring down the next pair, try subtracting 4*root+1
  always_comb begin
    rem4      = {sq_i.rem, sq_i.s[61:60]};
    trial     = {2'b00, sq_i.root, 2'b01};
    ge        = rem4 >= trial;
    sq_d.rem  = ge ? 61'(rem4 - trial) : rem4[60:0];
    sq_d.root = {sq_i.root[57:0], ge};
    sq_d.s    = {sq_i.s[59:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      ctx_q <= ctx_i;
    end
  end

  assign vld_o = vld_q;
  assign sq_o  = sq_q;
  assign ctx_o = ctx_q;

endmodule

FILE: hw/rtl/obn_div_cell.sv
module obn_div_cell import obn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  dv_t  dv_i,
  input  ctx_t ctx_i,
  output logic vld_o,
  output dv_t  dv_o,
  output ctx_t ctx_o
);

  logic [2:0][59:0] r2;
  logic [2:0]       ge;
  dv_t              dv_d, dv_q;
  ctx_t             ctx_q;
  logic             vld_q;

  // one quotient bit for each of the three lanes
  always_comb begin
    dv_d.den = dv_i.den;
    for (int i = 0; i < 3; i++) begin
      r2[i]      = {dv_i.r[i], 1'b0};
      ge[i]      = r2[i] >= {1'b0, dv_i.den};
      dv_d.r[i]  = ge[i] ? 59'(r2[i] - {1'b0, dv_i.den}) : r2[i][58:0];
      dv_d.q[i]  = {dv_i.q[i][29:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q  <= dv_d;
      ctx_q <= ctx_i;
    end
  end

  assign vld_o = vld_q;
  assign dv_o  = dv_q;
  assign ctx_o = ctx_q;

endmodule

FILE: hw/rtl/obn_unit3.sv
module obn_unit3 import obn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  wide_t [2:0] vec_i,
  input  side_t       side_i,
  output logic        vld_o,
  output nint_t [2:0] norm_o,
  output unit_t [2:0] unit_o,
  output side_t       side_o
);

  // front stages: magnitude, three normalize stages, squares, sum
  logic [5:0]       vld_q;
  logic [5:0][2:0]  neg_q;
  side_t [5:0]      side_q;
  logic [2:0]       neg_d;
  mag3_t            m1_d, m1_q, m2_q, m3_q, m4_d;
  logic [2:0][29:0] mu4_q, mu5_q;
  logic [2:0][59:0] sqr_q;
  logic             zero4_q, zero5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][62];
      m1_d[i]  = neg_d[i] ? 62'(-vec_i[i]) : 62'(vec_i[i]);
    end
    m4_d = norm_step(norm_step(m3_q, 2), 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= {neg_q[4:0], neg_d};
      side_q <= {side_q[4:0], side_i};
      m1_q   <= m1_d;
      m2_q   <= norm_step(norm_step(m1_q, 32), 16);
      m3_q   <= norm_step(norm_step(m2_q, 8), 4);
      for (int i = 0; i < 3; i++) begin
        mu4_q[i] <= m4_d[i][61:32];
        sqr_q[i] <= mu4_q[i] * mu4_q[i];
      end
      zero4_q <= (m4_d[0] | m4_d[1] | m4_d[2]) == '0;
      mu5_q   <= mu4_q;
      zero5_q <= zero4_q;
    end
  end

  // square root chain
  sq_t  sqc   [0:SqrtSteps];
  ctx_t sctx  [0:SqrtSteps];
  logic svld  [0:SqrtSteps];

  sq_t  sq6_q;
  ctx_t ctx6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq6_q.s      <= 62'(sqr_q[0]) + 62'(sqr_q[1]) + 62'(sqr_q[2]);
      sq6_q.rem    <= '0;
      sq6_q.root   <= '0;
      ctx6_q.zero  <= zero5_q;
      ctx6_q.neg   <= neg_q[4];
      ctx6_q.mag   <= mu5_q;
      ctx6_q.side  <= side_q[4];
    end
  end

  assign sqc[0]  = sq6_q;
  assign sctx[0] = ctx6_q;
  assign svld[0] = vld_q[5];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    obn_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en_i),
      .vld_i (svld[k]),
      .sq_i  (sqc[k]),
      .ctx_i (sctx[k]),
      .vld_o (svld[k+1]),
      .sq_o  (sqc[k+1]),
      .ctx_o (sctx[k+1])
    );
  end

  // division chain, all three components against the same length
  dv_t  dvc  [0:DivSteps];
  ctx_t dctx [0:DivSteps];
  logic dvld [0:DivSteps];

  always_comb begin
    dvc[0].den = sqc[SqrtSteps].root;
    for (int i = 0; i < 3; i++) begin
      dvc[0].r[i] = {29'd0, sctx[SqrtSteps].mag[i]};
      dvc[0].q[i] = '0;
    end
  end
  assign dctx[0] = sctx[SqrtSteps];
  assign dvld[0] = svld[SqrtSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    obn_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en_i),
      .vld_i (dvld[k]),
      .dv_i  (dvc[k]),
      .ctx_i (dctx[k]),
      .vld_o (dvld[k+1]),
      .dv_o  (dvc[k+1]),
      .ctx_o (dctx[k+1])
    );
  end

  // clamp, restore signs, zero vector gives zeros
  logic        ovld_q;
  nint_t [2:0] norm_d, norm_q;
  unit_t [2:0] unit_d, unit_q;
  side_t       oside_q;
  logic [30:0] uc;
  ctx_t        fc;

  always_comb begin
    fc = dctx[DivSteps];
    for (int i = 0; i < 3; i++) begin
      uc        = (dvc[DivSteps].q[i] > UnitCap) ? UnitCap : dvc[DivSteps].q[i];
      unit_d[i] = fc.neg[i] ? -unit_t'({1'b0, uc}) : unit_t'({1'b0, uc});
      norm_d[i] = fc.neg[i] ? -nint_t'({1'b0, fc.mag[i]}) : nint_t'({1'b0, fc.mag[i]});
      if (fc.zero) begin
        unit_d[i] = '0;
        norm_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (en_i) begin
      ovld_q <= dvld[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q  <= norm_d;
      unit_q  <= unit_d;
      oside_q <= fc.side;
    end
  end

  assign vld_o  = ovld_q;
  assign norm_o = norm_q;
  assign unit_o = unit_q;
  assign side_o = oside_q;

endmodule

FILE: hw/rtl/orthonormal_basis_from_normal_core.sv
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, and stalls as one otherwise.
// Each of the three normalizers is a 124-stage chain (59 square root cells,
// 58 divider cells). Reset clears all valid bits; zero_threshold resets to 11.
module orthonormal_basis_from_normal_core import obn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic en;
  logic u3_vld;

  assign en         = !u3_vld || out_ready_i;
  assign in_ready_o = en;

  // config register
  logic [30:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 31'd11;
    end else if (psel && penable && pwrite && (paddr[2] == RegZeroThr)) begin
      thr_q <= pwdata[30:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegZeroThr) ? {1'b0, thr_q} : '0;

  // normalize the input normal
  wide_t [2:0] n_vec;
  logic        u1_vld;
  nint_t [2:0] u1_norm;
  unit_t [2:0] u1_unit;
  side_t       u1_side;

  assign n_vec[0] = {{31{in_data_i.normal_x[31]}}, in_data_i.normal_x};
  assign n_vec[1] = {{31{in_data_i.normal_y[31]}}, in_data_i.normal_y};
  assign n_vec[2] = {{31{in_data_i.normal_z[31]}}, in_data_i.normal_z};

  obn_unit3 u_norm_n (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (in_valid_i && in_ready_o),
    .vec_i (n_vec),
    .side_i('0),
    .vld_o (u1_vld),
    .norm_o(u1_norm),
    .unit_o(u1_unit),
    .side_o(u1_side)
  );

  // pick a component, build the perpendicular vector
  logic        pk_vld_q;
  wide_t [2:0] pk_vec_d, pk_vec_q;
  side_t       pk_side_d, pk_side_q;
  logic [2:0]  above;
  logic [31:0] uabs;
  wide_t [2:0] nx, nneg, nabs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uabs     = u1_unit[i][31] ? 32'(-u1_unit[i]) : u1_unit[i];
      above[i] = uabs[30:0] > thr_q;
      nx[i]    = {{32{u1_norm[i][30]}}, u1_norm[i]};
      nneg[i]  = -nx[i];
      nabs[i]  = u1_norm[i][30] ? nneg[i] : nx[i];
    end
    pk_vec_d = '0;
    if (above[0]) begin
      pk_vec_d[0] = u1_norm[0][30] ? nx[1] : nneg[1];
      pk_vec_d[1] = nabs[0];
    end else if (above[1]) begin
      pk_vec_d[0] = nabs[1];
      pk_vec_d[1] = u1_norm[1][30] ? nx[0] : nneg[0];
    end else begin
      pk_vec_d[0] = nabs[2];
      pk_vec_d[2] = u1_norm[2][30] ? nx[0] : nneg[0];
    end
    pk_side_d     = '0;
    pk_side_d.nn  = u1_norm;
    pk_side_d.deg = (above == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_vld_q <= 1'b0;
    end else if (en) begin
      pk_vld_q <= u1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_vec_q  <= pk_vec_d;
      pk_side_q <= pk_side_d;
    end
  end

  // normalize the perpendicular vector
  logic        u2_vld;
  nint_t [2:0] u2_norm;
  unit_t [2:0] u2_unit;
  side_t       u2_side;

  obn_unit3 u_norm_a (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (pk_vld_q),
    .vec_i (pk_vec_q),
    .side_i(pk_side_q),
    .vld_o (u2_vld),
    .norm_o(u2_norm),
    .unit_o(u2_unit),
    .side_o(u2_side)
  );

  // cross product: products, then differences
  logic             pr_vld_q, df_vld_q;
  logic [5:0][61:0] pr_q;
  side_t            pr_side_q, df_side_q;
  wide_t [2:0]      df_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
      df_vld_q <= 1'b0;
    end else if (en) begin
      pr_vld_q <= u2_vld;
      df_vld_q <= pr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0]      <= $signed(u2_side.nn[1]) * $signed(u2_norm[2]);
      pr_q[1]      <= $signed(u2_side.nn[2]) * $signed(u2_norm[1]);
      pr_q[2]      <= $signed(u2_side.nn[2]) * $signed(u2_norm[0]);
      pr_q[3]      <= $signed(u2_side.nn[0]) * $signed(u2_norm[2]);
      pr_q[4]      <= $signed(u2_side.nn[0]) * $signed(u2_norm[1]);
      pr_q[5]      <= $signed(u2_side.nn[1]) * $signed(u2_norm[0]);
      pr_side_q    <= '0;
      pr_side_q.ua <= u2_unit;
      pr_side_q.deg <= u2_side.deg;
      for (int i = 0; i < 3; i++) begin
        df_vec_q[i] <= {pr_q[2*i][61], pr_q[2*i]} - {pr_q[2*i+1][61], pr_q[2*i+1]};
      end
      df_side_q <= pr_side_q;
    end
  end

  // normalize the cross product
  nint_t [2:0] u3_norm;
  unit_t [2:0] u3_unit;
  side_t       u3_side;

  obn_unit3 u_norm_c (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (df_vld_q),
    .vec_i (df_vec_q),
    .side_i(df_side_q),
    .vld_o (u3_vld),
    .norm_o(u3_norm),
    .unit_o(u3_unit),
    .side_o(u3_side)
  );

  // result word, zeros when degenerate
  logic unused_norm;
  assign unused_norm = ^{u3_norm, u1_side};

  always_comb begin
    out_data_o            = '0;
    out_data_o.degenerate = u3_side.deg;
    if (!u3_side.deg) begin
      out_data_o.first_x  = u3_side.ua[0];
      out_data_o.first_y  = u3_side.ua[1];
      out_data_o.first_z  = u3_side.ua[2];
      out_data_o.second_x = u3_unit[0];
      out_data_o.second_y = u3_unit[1];
      out_data_o.second_z = u3_unit[2] ^ {32{unused_norm & 1'b0}};
    end
  end

  assign out_valid_o = u3_vld;

endmodule
